// ===== sv/line_segment_intersection_core_assert.svh =====
// Assertion macros for the line segment intersection RTL.
`ifndef LINE_SEGMENT_INTERSECTION_CORE_ASSERT_SVH
`define LINE_SEGMENT_INTERSECTION_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define LSI_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lsi assertion failed: same-cycle implication");
`define LSI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lsi assertion failed: next-cycle implication");
`else
`define LSI_ASSERT_IMPL(label, clk, rst, ante, cons)
`define LSI_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== sv/lsi_pkg.sv =====
// Widths, constants and word types of the line segment intersection core.
`default_nettype none
package lsi_pkg;
   localparam int CoordBits = 16;
   localparam int FracBits  = 16;
   localparam int OutBits   = 48;
   localparam int DiffBits  = CoordBits + 1;
   localparam int DetBits   = 2 * CoordBits + 3;
   localparam int TermBits  = 2 * CoordBits + 1;
   localparam int ProdBits  = 3 * CoordBits + 2;
   localparam int NumBits   = 3 * CoordBits + 3;
   localparam int QuoBits   = NumBits + FracBits;
   localparam int SatBits   = (QuoBits > OutBits) ? QuoBits : OutBits + 1;

   localparam logic [OutBits-1:0] LIM_POS = {1'b0, {(OutBits-1){1'b1}}};
   localparam logic [OutBits-1:0] LIM_NEG = {1'b1, {(OutBits-1){1'b0}}};

   typedef logic signed [CoordBits-1:0] coord_type;

   typedef struct packed {
      logic               meet;
      logic               contained;
      logic               neg_x;
      logic               neg_y;
      logic [NumBits-1:0] mag_x;
      logic [NumBits-1:0] mag_y;
      logic [DetBits-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic               meet;
      logic               contained;
      logic               neg_x;
      logic               neg_y;
      logic [QuoBits-1:0] quo_x;
      logic [QuoBits-1:0] quo_y;
   } div_rsp_type;
endpackage
`default_nettype wire

// ===== sv/line_segment_intersection_core.sv =====
// Top level of the line segment intersection core.
//
//   Channel   Direction  Handshake              Word
//   req_      in         req_valid/req_ready    two segments, four signed endpoints
//   rsp_      out        rsp_valid/rsp_ready    crossing point (Q32.16) and three flags
//
// The pipeline has six front stages, one divider stage per quotient bit and one
// saturation stage. A new word can be taken every cycle while the output is not
// stalled; the pipeline depth is set by the bit-serial divider chain. Reset is
// synchronous and clears only the valid bits.
// When the output register holds a word that is not taken, the whole pipeline
// holds and req_ready drops in the same cycle; nothing is lost or repeated.
`default_nettype none
`include "line_segment_intersection_core_assert.svh"
module line_segment_intersection_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire lsi_pkg::coord_type          req_seg1_start_x,
   input  wire lsi_pkg::coord_type          req_seg1_start_y,
   input  wire lsi_pkg::coord_type          req_seg1_end_x,
   input  wire lsi_pkg::coord_type          req_seg1_end_y,
   input  wire lsi_pkg::coord_type          req_seg2_start_x,
   input  wire lsi_pkg::coord_type          req_seg2_start_y,
   input  wire lsi_pkg::coord_type          req_seg2_end_x,
   input  wire lsi_pkg::coord_type          req_seg2_end_y,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic signed [lsi_pkg::OutBits-1:0] rsp_cross_x,
   output logic signed [lsi_pkg::OutBits-1:0] rsp_cross_y,
   output logic                             rsp_lines_meet,
   output logic                             rsp_within_both,
   output logic                             rsp_clipped
);
   import lsi_pkg::*;

   // Clamp a quotient magnitude to the signed output range and apply the sign.
   // The top bit of the result is the clip flag.
   function automatic logic [OutBits:0] saturate(
      input logic [QuoBits-1:0] quo,
      input logic               neg
   );
      logic [SatBits-1:0] qe;
      logic [SatBits-1:0] lim;
      logic [OutBits-1:0] val;
      logic               over;
      qe   = SatBits'(quo);
      lim  = neg ? SatBits'(LIM_NEG) : SatBits'(LIM_POS);
      over = (qe > lim);
      val  = over ? lim[OutBits-1:0] : qe[OutBits-1:0];
      return {over, neg ? -val : val};
   endfunction

   logic                en;
   logic                front_valid;
   div_req_type         front_req;
   logic                div_valid;
   div_rsp_type         div_rsp;
   logic [OutBits:0]    sat_x, sat_y;

   logic                rsp_valid_ff;
   logic [OutBits-1:0]  cross_x_ff, cross_x_in;
   logic [OutBits-1:0]  cross_y_ff, cross_y_in;
   logic                meet_ff, within_ff, clipped_ff;
   logic                clipped_in;

   // The pipeline moves whenever the output register is empty or being drained.
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   lsi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .x1        (req_seg1_start_x),
      .y1        (req_seg1_start_y),
      .x2        (req_seg1_end_x),
      .y2        (req_seg1_end_y),
      .x3        (req_seg2_start_x),
      .y3        (req_seg2_start_y),
      .x4        (req_seg2_end_x),
      .y4        (req_seg2_end_y),
      .out_valid (front_valid),
      .out_req   (front_req)
   );

   lsi_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_req    (front_req),
      .out_valid (div_valid),
      .out_rsp   (div_rsp)
   );

   // Parallel lines give a zero point with every flag clear.
   always_comb begin
      sat_x      = saturate(div_rsp.quo_x, div_rsp.neg_x);
      sat_y      = saturate(div_rsp.quo_y, div_rsp.neg_y);
      cross_x_in = div_rsp.meet ? sat_x[OutBits-1:0] : '0;
      cross_y_in = div_rsp.meet ? sat_y[OutBits-1:0] : '0;
      clipped_in = div_rsp.meet & (sat_x[OutBits] | sat_y[OutBits]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cross_x_ff <= cross_x_in;
         cross_y_ff <= cross_y_in;
         meet_ff    <= div_rsp.meet;
         within_ff  <= div_rsp.contained;
         clipped_ff <= clipped_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cross_x     = cross_x_ff;
   assign rsp_cross_y     = cross_y_ff;
   assign rsp_lines_meet  = meet_ff;
   assign rsp_within_both = within_ff;
   assign rsp_clipped     = clipped_ff;

   `LSI_ASSERT_IMPL(a_parallel_zero, clock, reset, rsp_valid && !rsp_lines_meet, rsp_cross_x == '0 && rsp_cross_y == '0 && !rsp_within_both && !rsp_clipped)
   `LSI_ASSERT_IMPL(a_clip_at_limit, clock, reset, rsp_valid && rsp_clipped, rsp_cross_x == LIM_POS || rsp_cross_x == LIM_NEG || rsp_cross_y == LIM_POS || rsp_cross_y == LIM_NEG)
   `LSI_ASSERT_IMPL(a_within_meets, clock, reset, rsp_valid && rsp_within_both, rsp_lines_meet)
   `LSI_ASSERT_NEXT(a_divider_drains, clock, reset, div_valid && en, rsp_valid)
endmodule
`default_nettype wire

// ===== sv/lsi_front.sv =====
// Six-stage front end: determinant, numerators, magnitudes and bounds test.
`default_nettype none
module lsi_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               in_valid,
   input  wire lsi_pkg::coord_type x1,
   input  wire lsi_pkg::coord_type y1,
   input  wire lsi_pkg::coord_type x2,
   input  wire lsi_pkg::coord_type y2,
   input  wire lsi_pkg::coord_type x3,
   input  wire lsi_pkg::coord_type y3,
   input  wire lsi_pkg::coord_type x4,
   input  wire lsi_pkg::coord_type y4,
   output logic                    out_valid,
   output lsi_pkg::div_req_type    out_req
);
   import lsi_pkg::*;

   // Bound order: x of segment one, x of segment two, y of one, y of two.
   logic [5:0] vld_ff;

   logic signed [DiffBits-1:0] s1_dx12_ff, s1_dy12_ff, s1_dx34_ff, s1_dy34_ff;
   coord_type s1_x1_ff, s1_y1_ff, s1_x2_ff, s1_y2_ff;
   coord_type s1_x3_ff, s1_y3_ff, s1_x4_ff, s1_y4_ff;
   coord_type s1_lo_ff [4];
   coord_type s1_hi_ff [4];
   coord_type s1_lo_in [4];
   coord_type s1_hi_in [4];

   logic signed [2*DiffBits-1:0]  s2_pa_ff, s2_pb_ff;
   logic signed [2*CoordBits-1:0] s2_ta_ff, s2_tb_ff, s2_tc_ff, s2_td_ff;
   logic signed [DiffBits-1:0]    s2_dx12_ff, s2_dy12_ff, s2_dx34_ff, s2_dy34_ff;
   coord_type s2_lo_ff [4];
   coord_type s2_hi_ff [4];

   logic signed [DetBits-1:0]  s3_d_ff;
   logic signed [TermBits-1:0] s3_t1_ff, s3_t2_ff;
   logic signed [DiffBits-1:0] s3_dx12_ff, s3_dy12_ff, s3_dx34_ff, s3_dy34_ff;
   coord_type s3_lo_ff [4];
   coord_type s3_hi_ff [4];

   logic signed [ProdBits-1:0] s4_m1_ff, s4_m2_ff, s4_m3_ff, s4_m4_ff;
   logic signed [DetBits-1:0]  s4_dp_ff;
   logic                       s4_dneg_ff, s4_meet_ff;
   coord_type s4_lo_ff [4];
   coord_type s4_hi_ff [4];

   logic signed [NumBits-1:0] s5_nx_ff, s5_ny_ff;
   logic signed [NumBits-1:0] s5_blo_ff [4];
   logic signed [NumBits-1:0] s5_bhi_ff [4];
   logic signed [DetBits-1:0] s5_dp_ff;
   logic                      s5_dneg_ff, s5_meet_ff;

   div_req_type s6_req_ff;

   logic signed [NumBits-1:0] adj_x, adj_y;
   logic                      within_in;

   always_comb begin
      s1_lo_in[0] = (x1 < x2) ? x1 : x2;
      s1_hi_in[0] = (x1 < x2) ? x2 : x1;
      s1_lo_in[1] = (x3 < x4) ? x3 : x4;
      s1_hi_in[1] = (x3 < x4) ? x4 : x3;
      s1_lo_in[2] = (y1 < y2) ? y1 : y2;
      s1_hi_in[2] = (y1 < y2) ? y2 : y1;
      s1_lo_in[3] = (y3 < y4) ? y3 : y4;
      s1_hi_in[3] = (y3 < y4) ? y4 : y3;
   end

   // The point is tested against each bound scaled by the positive determinant.
   always_comb begin
      adj_x = s5_dneg_ff ? -s5_nx_ff : s5_nx_ff;
      adj_y = s5_dneg_ff ? -s5_ny_ff : s5_ny_ff;
      within_in = (adj_x >= s5_blo_ff[0]) && (adj_x <= s5_bhi_ff[0]) &&
                  (adj_x >= s5_blo_ff[1]) && (adj_x <= s5_bhi_ff[1]) &&
                  (adj_y >= s5_blo_ff[2]) && (adj_y <= s5_bhi_ff[2]) &&
                  (adj_y >= s5_blo_ff[3]) && (adj_y <= s5_bhi_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_dx12_ff <= DiffBits'(x1) - DiffBits'(x2);
         s1_dy12_ff <= DiffBits'(y1) - DiffBits'(y2);
         s1_dx34_ff <= DiffBits'(x3) - DiffBits'(x4);
         s1_dy34_ff <= DiffBits'(y3) - DiffBits'(y4);
         s1_x1_ff <= x1;
         s1_y1_ff <= y1;
         s1_x2_ff <= x2;
         s1_y2_ff <= y2;
         s1_x3_ff <= x3;
         s1_y3_ff <= y3;
         s1_x4_ff <= x4;
         s1_y4_ff <= y4;
         s1_lo_ff <= s1_lo_in;
         s1_hi_ff <= s1_hi_in;

         s2_pa_ff <= (2*DiffBits)'(s1_dx12_ff) * (2*DiffBits)'(s1_dy34_ff);
         s2_pb_ff <= (2*DiffBits)'(s1_dy12_ff) * (2*DiffBits)'(s1_dx34_ff);
         s2_ta_ff <= (2*CoordBits)'(s1_x1_ff) * (2*CoordBits)'(s1_y2_ff);
         s2_tb_ff <= (2*CoordBits)'(s1_y1_ff) * (2*CoordBits)'(s1_x2_ff);
         s2_tc_ff <= (2*CoordBits)'(s1_x3_ff) * (2*CoordBits)'(s1_y4_ff);
         s2_td_ff <= (2*CoordBits)'(s1_y3_ff) * (2*CoordBits)'(s1_x4_ff);
         s2_dx12_ff <= s1_dx12_ff;
         s2_dy12_ff <= s1_dy12_ff;
         s2_dx34_ff <= s1_dx34_ff;
         s2_dy34_ff <= s1_dy34_ff;
         s2_lo_ff <= s1_lo_ff;
         s2_hi_ff <= s1_hi_ff;

         s3_d_ff  <= DetBits'(s2_pa_ff) - DetBits'(s2_pb_ff);
         s3_t1_ff <= TermBits'(s2_ta_ff) - TermBits'(s2_tb_ff);
         s3_t2_ff <= TermBits'(s2_tc_ff) - TermBits'(s2_td_ff);
         s3_dx12_ff <= s2_dx12_ff;
         s3_dy12_ff <= s2_dy12_ff;
         s3_dx34_ff <= s2_dx34_ff;
         s3_dy34_ff <= s2_dy34_ff;
         s3_lo_ff <= s2_lo_ff;
         s3_hi_ff <= s2_hi_ff;

         s4_m1_ff <= ProdBits'(s3_t1_ff) * ProdBits'(s3_dx34_ff);
         s4_m2_ff <= ProdBits'(s3_dx12_ff) * ProdBits'(s3_t2_ff);
         s4_m3_ff <= ProdBits'(s3_t1_ff) * ProdBits'(s3_dy34_ff);
         s4_m4_ff <= ProdBits'(s3_dy12_ff) * ProdBits'(s3_t2_ff);
         s4_dp_ff   <= s3_d_ff[DetBits-1] ? -s3_d_ff : s3_d_ff;
         s4_dneg_ff <= s3_d_ff[DetBits-1];
         s4_meet_ff <= (s3_d_ff != '0);
         s4_lo_ff <= s3_lo_ff;
         s4_hi_ff <= s3_hi_ff;

         s5_nx_ff <= NumBits'(s4_m1_ff) - NumBits'(s4_m2_ff);
         s5_ny_ff <= NumBits'(s4_m3_ff) - NumBits'(s4_m4_ff);
         for (int k = 0; k < 4; k++) begin
            s5_blo_ff[k] <= NumBits'(s4_lo_ff[k]) * NumBits'(s4_dp_ff);
            s5_bhi_ff[k] <= NumBits'(s4_hi_ff[k]) * NumBits'(s4_dp_ff);
         end
         s5_dp_ff   <= s4_dp_ff;
         s5_dneg_ff <= s4_dneg_ff;
         s5_meet_ff <= s4_meet_ff;

         s6_req_ff.meet      <= s5_meet_ff;
         s6_req_ff.contained <= s5_meet_ff & within_in;
         s6_req_ff.neg_x     <= s5_nx_ff[NumBits-1] ^ s5_dneg_ff;
         s6_req_ff.neg_y     <= s5_ny_ff[NumBits-1] ^ s5_dneg_ff;
         s6_req_ff.mag_x     <= s5_nx_ff[NumBits-1] ? -s5_nx_ff : s5_nx_ff;
         s6_req_ff.mag_y     <= s5_ny_ff[NumBits-1] ? -s5_ny_ff : s5_ny_ff;
         s6_req_ff.den       <= s5_dp_ff;
      end
   end

   assign out_valid = vld_ff[5];
   assign out_req   = s6_req_ff;
endmodule
`default_nettype wire

// ===== sv/lsi_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing a divisor.
`default_nettype none
module lsi_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  wire lsi_pkg::div_req_type in_req,
   output logic                      out_valid,
   output lsi_pkg::div_rsp_type      out_rsp
);
   import lsi_pkg::*;

   typedef struct packed {
      logic               meet;
      logic               contained;
      logic               neg_x;
      logic               neg_y;
      logic [DetBits-1:0] den;
      logic [DetBits-1:0] rem_x;
      logic [DetBits-1:0] rem_y;
      logic [QuoBits-1:0] dvd_x;
      logic [QuoBits-1:0] dvd_y;
   } stage_type;

   // The dividend shifts out at the top while quotient bits shift in at the bottom.
   function automatic logic [DetBits+QuoBits-1:0] div_step(
      input logic [DetBits-1:0] rem,
      input logic [QuoBits-1:0] dvd,
      input logic [DetBits-1:0] den
   );
      logic [DetBits:0]   trial;
      logic               ge;
      logic [DetBits-1:0] rem_next;
      trial    = {rem, dvd[QuoBits-1]};
      ge       = (trial >= {1'b0, den});
      rem_next = ge ? DetBits'(trial - {1'b0, den}) : trial[DetBits-1:0];
      return {rem_next, dvd[QuoBits-2:0], ge};
   endfunction

   stage_type          st_ff [QuoBits];
   stage_type          st_in [QuoBits];
   logic [QuoBits-1:0] vld_ff;
   stage_type          head;

   always_comb begin
      head.meet      = in_req.meet;
      head.contained = in_req.contained;
      head.neg_x     = in_req.neg_x;
      head.neg_y     = in_req.neg_y;
      head.den       = in_req.den;
      head.rem_x     = '0;
      head.rem_y     = '0;
      head.dvd_x     = QuoBits'(in_req.mag_x) << FracBits;
      head.dvd_y     = QuoBits'(in_req.mag_y) << FracBits;
   end

   for (genvar k = 0; k < QuoBits; k++) begin : g_stage
      stage_type prev;
      if (k == 0) begin : g_first
         assign prev = head;
      end else begin : g_rest
         assign prev = st_ff[k-1];
      end
      always_comb begin
         st_in[k] = prev;
         {st_in[k].rem_x, st_in[k].dvd_x} = div_step(prev.rem_x, prev.dvd_x, prev.den);
         {st_in[k].rem_y, st_in[k].dvd_y} = div_step(prev.rem_y, prev.dvd_y, prev.den);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[QuoBits-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff <= st_in;
      end
   end

   assign out_valid         = vld_ff[QuoBits-1];
   assign out_rsp.meet      = st_ff[QuoBits-1].meet;
   assign out_rsp.contained = st_ff[QuoBits-1].contained;
   assign out_rsp.neg_x     = st_ff[QuoBits-1].neg_x;
   assign out_rsp.neg_y     = st_ff[QuoBits-1].neg_y;
   assign out_rsp.quo_x     = st_ff[QuoBits-1].dvd_x;
   assign out_rsp.quo_y     = st_ff[QuoBits-1].dvd_y;
endmodule
`default_nettype wire
